@@ hdl/fgmnt_pkg.sv @@
`default_nettype none
package fgmnt_pkg;

    localparam int GRID_CELLS = 64;
    localparam int GRID_W     = $clog2(GRID_CELLS);
    localparam int ADDR_W     = 2 * GRID_W;
    localparam int POS_W      = 7;
    localparam int COORD_W    = 8;
    localparam int WIDE_W     = COORD_W + 1;
    localparam int DIST_W     = 16;
    localparam int HALF_W     = 2;
    localparam int MARGIN_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HALF_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HALF_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_MARGIN    = 2'd2;

    typedef enum logic [1:0] {
        MARK_UNSEEN   = 2'd0,
        MARK_EXPLORED = 2'd1,
        MARK_FRONTIER = 2'd2,
        MARK_WALL     = 2'd3
    } mark_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WIN_RD,
        ST_WIN_WR,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } back_state_t;

    // Classified position: drone cell and clipped view window
    typedef struct packed {
        logic signed [COORD_W-1:0] row;
        logic signed [COORD_W-1:0] col;
        logic [GRID_W-1:0]         r0;
        logic [GRID_W-1:0]         rl;
        logic [GRID_W-1:0]         c0;
        logic [GRID_W-1:0]         cl;
        logic                      win_empty;
    } item_t;

    typedef struct packed {
        logic [HALF_W-1:0]   half_rows;
        logic [HALF_W-1:0]   half_cols;
        logic [MARGIN_W-1:0] margin;
    } cfg_t;

    typedef struct packed {
        logic push;
        logic full;
        logic pop;
        logic empty;
    } q_ctrl_t;

endpackage
`default_nettype wire

@@ hdl/fgmnt_front.sv @@
`default_nettype none
module fgmnt_front (
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [fgmnt_pkg::S_TDATA_W-1:0] s_tdata,   // pos_x[6:0], pos_y[13:7]
    input  wire fgmnt_pkg::cfg_t                 cfg,
    input  wire logic                            clearing,
    input  wire logic                            q_full,
    output logic                                 push,
    output fgmnt_pkg::item_t                     item
);
    import fgmnt_pkg::*;

    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic signed [WIDE_W-1:0] row9, col9, hr9, hc9;
    logic signed [WIDE_W-1:0] r_lo, r_hi, c_lo, c_hi;
    logic signed [WIDE_W-1:0] r0c, r1c, c0c, c1c;
    logic signed [WIDE_W-1:0] r_last, c_last;

    assign pos_x = s_tdata[POS_W-1:0];
    assign pos_y = s_tdata[2*POS_W-1:POS_W];

    always_comb begin
        row9 = WIDE_W'(GRID_CELLS) - $signed({2'b00, pos_x});
        col9 = WIDE_W'(GRID_CELLS / 2) - $signed({{2{pos_y[POS_W-1]}}, pos_y});
        hr9  = $signed({{(WIDE_W-HALF_W){1'b0}}, cfg.half_rows});
        hc9  = $signed({{(WIDE_W-HALF_W){1'b0}}, cfg.half_cols});
        r_lo = row9 - hr9;
        r_hi = row9 + hr9;
        c_lo = col9 - hc9;
        c_hi = col9 + hc9;
        // clip the window to the grid
        r0c = (r_lo < 0) ? '0 : r_lo;
        c0c = (c_lo < 0) ? '0 : c_lo;
        r1c = (r_hi > WIDE_W'(GRID_CELLS)) ? WIDE_W'(GRID_CELLS) : r_hi;
        c1c = (c_hi > WIDE_W'(GRID_CELLS)) ? WIDE_W'(GRID_CELLS) : c_hi;
        r_last = r1c - 9'sd1;
        c_last = c1c - 9'sd1;

        item.row       = row9[COORD_W-1:0];
        item.col       = col9[COORD_W-1:0];
        item.r0        = r0c[GRID_W-1:0];
        item.c0        = c0c[GRID_W-1:0];
        item.rl        = r_last[GRID_W-1:0];
        item.cl        = c_last[GRID_W-1:0];
        item.win_empty = (r0c >= r1c) || (c0c >= c1c);
    end

    assign s_tready = !clearing && !q_full;
    assign push     = s_tvalid && s_tready;

endmodule
`default_nettype wire

@@ hdl/fgmnt_queue.sv @@
`default_nettype none
module fgmnt_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire fgmnt_pkg::item_t wr_item,
    input  wire logic             pop,
    output fgmnt_pkg::item_t      rd_item,
    output logic                  full,
    output logic                  empty
);
    import fgmnt_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_item = entry_reg[rptr_reg];

    always_comb begin
        wptr_next  = push ? PTR_W'(wptr_reg + 1'b1) : wptr_reg;
        rptr_next  = pop  ? PTR_W'(rptr_reg + 1'b1) : rptr_reg;
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= wr_item;
        end
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push) else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop) else $error("queue read while empty");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> !empty) else $error("queue lost an item");

endmodule
`default_nettype wire

@@ hdl/fgmnt_back.sv @@
`default_nettype none
module fgmnt_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire fgmnt_pkg::cfg_t                 cfg,
    input  wire fgmnt_pkg::item_t                q_item,
    input  wire logic                            q_empty,
    output logic                                 pop,
    output logic                                 clearing,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [fgmnt_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                 m_tuser
);
    import fgmnt_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = {ADDR_W{1'b1}};

    logic [1:0]               mem [GRID_CELLS*GRID_CELLS];
    logic [1:0]               rd_data_reg;

    back_state_t              state_reg, state_next;
    item_t                    item_reg;
    logic [ADDR_W-1:0]        cnt_reg;
    logic [GRID_W-1:0]        wr_reg, wc_reg;

    logic                     s1_v_reg;
    logic [ADDR_W-1:0]        s1_addr_reg;
    logic                     s2_v_reg, s2_f_reg;
    logic [DIST_W-1:0]        s2_d_reg;
    logic [ADDR_W-1:0]        s2_addr_reg;

    logic                     found_reg;
    logic [POS_W-1:0]         best_r_reg, best_c_reg;
    logic [DIST_W-1:0]        best_d_reg;

    logic                     out_valid_reg, out_found_reg;
    logic [POS_W-1:0]         out_tx_reg, out_ty_reg;

    logic                     mem_we, issue, load_out;
    logic [ADDR_W-1:0]        mem_wa, mem_ra;
    logic [1:0]               mem_wd;
    logic                     win_last, is_wall, is_edge;
    logic [POS_W-1:0]         wall_hi;
    logic signed [WIDE_W-1:0] dr, dc;
    logic signed [2*WIDE_W-1:0] dr2, dc2;
    logic [DIST_W-1:0]        sq_dist;

    // mark rule for one window cell
    always_comb begin
        wall_hi = POS_W'(GRID_CELLS) - {3'b000, cfg.margin};
        is_wall = ({1'b0, wr_reg} <= {3'b000, cfg.margin}) || ({1'b0, wr_reg} >= wall_hi)
               || ({1'b0, wc_reg} <= {3'b000, cfg.margin}) || ({1'b0, wc_reg} >= wall_hi);
        is_edge = (wr_reg == item_reg.r0) || (wr_reg == item_reg.rl)
               || (wc_reg == item_reg.c0) || (wc_reg == item_reg.cl);
        win_last = (wr_reg == item_reg.rl) && (wc_reg == item_reg.cl);
    end

    // squared distance of the cell read last cycle
    always_comb begin
        dr   = $signed({item_reg.row[COORD_W-1], item_reg.row})
             - $signed({3'b000, s1_addr_reg[ADDR_W-1:GRID_W]});
        dc   = $signed({item_reg.col[COORD_W-1], item_reg.col})
             - $signed({3'b000, s1_addr_reg[GRID_W-1:0]});
        dr2  = dr * dr;
        dc2  = dc * dc;
        sq_dist = DIST_W'(dr2 + dc2);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (cnt_reg == LAST_ADDR) state_next = ST_IDLE;
            ST_IDLE:   if (!q_empty) state_next = q_item.win_empty ? ST_SCAN : ST_WIN_RD;
            ST_WIN_RD: state_next = ST_WIN_WR;
            ST_WIN_WR: state_next = win_last ? ST_SCAN : ST_WIN_RD;
            ST_SCAN:   if (cnt_reg == LAST_ADDR) state_next = ST_DRAIN;
            ST_DRAIN:  if (!s1_v_reg && !s2_v_reg) state_next = ST_DONE;
            ST_DONE:   if (!out_valid_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        mem_we   = 1'b0;
        mem_wa   = {wr_reg, wc_reg};
        mem_wd   = MARK_UNSEEN;
        mem_ra   = {wr_reg, wc_reg};
        pop      = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        clearing = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                clearing = 1'b1;
                mem_we   = 1'b1;
                mem_wa   = cnt_reg;
            end
            ST_IDLE:   pop = !q_empty;
            ST_WIN_RD: mem_ra = {wr_reg, wc_reg};
            ST_WIN_WR: begin
                if (rd_data_reg == MARK_UNSEEN || rd_data_reg == MARK_FRONTIER) begin
                    mem_we = 1'b1;
                    mem_wd = is_wall ? MARK_WALL : (is_edge ? MARK_FRONTIER : MARK_EXPLORED);
                end
            end
            ST_SCAN: begin
                mem_ra = cnt_reg;
                issue  = 1'b1;
            end
            ST_DRAIN:  ;
            ST_DONE:   load_out = !out_valid_reg || m_tready;
            default:   ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            item_reg <= q_item;
            wr_reg   <= q_item.r0;
            wc_reg   <= q_item.c0;
        end else if (state_reg == ST_WIN_WR) begin
            if (wc_reg == item_reg.cl) begin
                wc_reg <= item_reg.c0;
                wr_reg <= wr_reg + 1'b1;
            end else begin
                wc_reg <= wc_reg + 1'b1;
            end
        end
        s1_addr_reg <= cnt_reg;
        s2_f_reg    <= (rd_data_reg == MARK_FRONTIER);
        s2_d_reg    <= sq_dist;
        s2_addr_reg <= s1_addr_reg;
        if (pop) begin
            best_r_reg <= POS_W'(GRID_CELLS);
            best_c_reg <= POS_W'(GRID_CELLS / 2);
        end else if (s2_v_reg && s2_f_reg && (!found_reg || s2_d_reg < best_d_reg)) begin
            best_d_reg <= s2_d_reg;
            best_r_reg <= {1'b0, s2_addr_reg[ADDR_W-1:GRID_W]};
            best_c_reg <= {1'b0, s2_addr_reg[GRID_W-1:0]};
        end
        if (load_out) begin
            out_found_reg <= found_reg;
            out_tx_reg    <= POS_W'(GRID_CELLS) - best_r_reg;
            out_ty_reg    <= POS_W'(GRID_CELLS / 2) - best_c_reg;
        end
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            s1_v_reg  <= issue;
            s2_v_reg  <= s1_v_reg;
            if (pop) begin
                cnt_reg <= '0;
            end else if (state_reg == ST_CLEAR || state_reg == ST_SCAN) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (pop) begin
                found_reg <= 1'b0;
            end else if (s2_v_reg && s2_f_reg) begin
                found_reg <= 1'b1;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-2*POS_W){1'b0}}, out_ty_reg, out_tx_reg};
    assign m_tuser  = out_found_reg;

    a_default_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_found_reg) |-> (out_tx_reg == '0 && out_ty_reg == '0))
        else $error("no-frontier result not at default cell");
    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (state_reg == ST_IDLE && !s1_v_reg && !s2_v_reg))
        else $error("item taken while search pipeline busy");
    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> (!pop && !out_valid_reg))
        else $error("activity during clearing pass");

endmodule
`default_nettype wire

@@ hdl/frontier_grid_map_nearest_target_unit.sv @@
`default_nettype none
// Frontier grid map with nearest-target search.
// Input stream (s_*): one item per drone position, pos_x in s_tdata[6:0]
// (unsigned) and pos_y in s_tdata[13:7] (signed), in 0.1 m cell units.
// Result stream (m_*): one item per position, target_x in m_tdata[6:0],
// target_y in m_tdata[13:7], found in m_tuser.
// Config channel (cfg_*): index 0 view_half_rows, 1 view_half_cols,
// 2 wall_margin; write only while the block is idle.
// After reset the 64 x 64 mark memory is cleared one cell a cycle, and
// s_tready stays low for the clearing pass (config writes are still taken).
// Per position the back end reads and then updates each cell of the
// clipped view window (at most 36 cells, none if it is empty), then scans
// every grid cell in raster order through the single memory read port
// and drains its search pipeline. A two-entry queue holds classified
// positions while the back end is busy.
// The result sits in an output register; a stalled receiver holds the
// back end only when the next result is ready, not during its search.
module frontier_grid_map_nearest_target_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [fgmnt_pkg::S_TDATA_W-1:0]  s_tdata,   // pos_x[6:0], pos_y[13:7]
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [fgmnt_pkg::M_TDATA_W-1:0]       m_tdata,   // target_x[6:0], target_y[13:7]
    output logic                                  m_tuser,   // found[0]
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [fgmnt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fgmnt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fgmnt_pkg::*;

    cfg_t    cfg_reg;
    item_t   front_item, q_item;
    q_ctrl_t qc;
    logic    clearing;

    // Always take config writes; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_rows <= 2'd2;
            cfg_reg.half_cols <= 2'd1;
            cfg_reg.margin    <= 4'd2;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_VIEW_HALF_ROWS: cfg_reg.half_rows <= cfg_data[HALF_W-1:0];
                CFG_VIEW_HALF_COLS: cfg_reg.half_cols <= cfg_data[HALF_W-1:0];
                CFG_WALL_MARGIN:    cfg_reg.margin    <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Front end: accept a position and classify its window.
    fgmnt_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg      (cfg_reg),
        .clearing (clearing),
        .q_full   (qc.full),
        .push     (qc.push),
        .item     (front_item)
    );

    // Hold classified positions between the two ends.
    fgmnt_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (qc.push),
        .wr_item (front_item),
        .pop     (qc.pop),
        .rd_item (q_item),
        .full    (qc.full),
        .empty   (qc.empty)
    );

    // Back end: update the window, scan for the nearest frontier.
    fgmnt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_item   (q_item),
        .q_empty  (qc.empty),
        .pop      (qc.pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire
